// ===== rtl/fwr_pkg.sv =====
`timescale 1ns / 1ps

package fwr_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_REM = 2'd2,
    CMD_CLR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_value;
    logic [4:0]         fill_count;
  } rsp_t;

endpackage

// ===== rtl/fwr_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module fwr_ram #(
  parameter int Depth = 16,
  parameter int Width = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/fifo_with_remove_by_value.sv =====
`timescale 1ns / 1ps

// Bounded FIFO of 32-bit values with an extra command that removes the oldest
// entry equal to a given value while keeping the order of the others.
// A command item is taken at a rising edge where start is high and busy is low.
// Every command gives exactly one result item on rsp_o, shown for one cycle with
// done_o high; the receiver cannot stall, so a result must be taken when shown.
// The entries sit in a circular buffer in a RAM with one write port and one read
// port with a registered read; a head pointer and a count register track it.
// Enqueue, clear, an enqueue on a full queue and a dequeue or remove on an empty
// queue finish in the accept cycle: the result appears in the next cycle and busy
// stays low, so such items can follow each cycle. Dequeue passes through the
// DEQ state, since the head entry must be read first.
// Remove of a non-empty queue, found or not, does one read per entry to find the
// match and then one read-and-write per younger entry to close the gap, all
// through the single read port. The result appears in the same cycle busy falls.
// Reset clears the count, the pointer and the state machine; the RAM contents are
// not cleared, since no entry is read before it has been written.
module fifo_with_remove_by_value (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fwr_pkg::req_t req_i,
  output logic          done_o,
  output fwr_pkg::rsp_t rsp_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DEQ   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [fwr_pkg::PTR_W-1:0]   head_q, head_d;
  logic [fwr_pkg::CNT_W-1:0]   count_q, count_d;
  logic [fwr_pkg::CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic [31:0]                 val_q, val_d;
  logic                        done_q, done_d;
  fwr_pkg::rsp_t               rsp_q, rsp_d;

  logic                        mem_we;
  logic [fwr_pkg::PTR_W-1:0]   mem_waddr;
  logic [31:0]                 mem_wdata;
  logic [fwr_pkg::PTR_W-1:0]   mem_raddr;
  logic [31:0]                 mem_rdata;

  logic                        accept;
  logic                        is_last;

  // Maps a position in queue order to a RAM address.
  function automatic logic [fwr_pkg::PTR_W-1:0] phys(
    input logic [fwr_pkg::PTR_W-1:0] head,
    input logic [fwr_pkg::CNT_W-1:0] pos
  );
    logic [fwr_pkg::CNT_W:0] sum;
    sum = (fwr_pkg::CNT_W + 1)'(head) + (fwr_pkg::CNT_W + 1)'(pos);
    if (sum >= (fwr_pkg::CNT_W + 1)'(fwr_pkg::DEPTH)) begin
      sum = sum - (fwr_pkg::CNT_W + 1)'(fwr_pkg::DEPTH);
    end
    return sum[fwr_pkg::PTR_W-1:0];
  endfunction

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  // True when the read data now arriving belongs to the youngest entry.
  assign is_last = (rd_idx_q == fwr_pkg::CNT_W'(count_q - 1'b1));

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    val_d     = val_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = phys(head_q, count_q);
    mem_wdata = val_q;
    // During a search or a shift the next entry is always fetched ahead; a
    // fetch past the youngest entry is simply dropped.
    mem_raddr = phys(head_q, fwr_pkg::CNT_W'(rd_idx_q + 1'b1));

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = head_q;
        if (accept) begin
          rsp_d.status    = fwr_pkg::ST_OK;
          rsp_d.out_value = '0;
          unique case (req_i.cmd)
            fwr_pkg::CMD_ENQ: begin
              done_d = 1'b1;
              if (count_q == fwr_pkg::CNT_W'(fwr_pkg::DEPTH)) begin
                rsp_d.status = fwr_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = req_i.item_value;
                count_d   = fwr_pkg::CNT_W'(count_q + 1'b1);
              end
            end
            fwr_pkg::CMD_DEQ: begin
              if (count_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = fwr_pkg::ST_EMPTY;
              end else begin
                state_d = S_DEQ;
              end
            end
            fwr_pkg::CMD_REM: begin
              if (count_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = fwr_pkg::ST_NOTFOUND;
              end else begin
                rd_idx_d = '0;
                val_d    = req_i.item_value;
                state_d  = S_SCAN;
              end
            end
            fwr_pkg::CMD_CLR: begin
              done_d  = 1'b1;
              count_d = '0;
            end
          endcase
        end
      end
      S_DEQ: begin
        done_d          = 1'b1;
        rsp_d.out_value = mem_rdata;
        head_d          = phys(head_q, fwr_pkg::CNT_W'(1));
        count_d         = fwr_pkg::CNT_W'(count_q - 1'b1);
        state_d         = S_IDLE;
      end
      S_SCAN: begin
        if (mem_rdata == val_q) begin
          rsp_d.out_value = mem_rdata;
          if (is_last) begin
            done_d  = 1'b1;
            count_d = fwr_pkg::CNT_W'(count_q - 1'b1);
            state_d = S_IDLE;
          end else begin
            rd_idx_d = fwr_pkg::CNT_W'(rd_idx_q + 1'b1);
            state_d  = S_SHIFT;
          end
        end else if (is_last) begin
          done_d       = 1'b1;
          rsp_d.status = fwr_pkg::ST_NOTFOUND;
          state_d      = S_IDLE;
        end else begin
          rd_idx_d = fwr_pkg::CNT_W'(rd_idx_q + 1'b1);
        end
      end
      S_SHIFT: begin
        // Move the arriving entry one place toward the head.
        mem_we    = 1'b1;
        mem_waddr = phys(head_q, fwr_pkg::CNT_W'(rd_idx_q - 1'b1));
        mem_wdata = mem_rdata;
        if (is_last) begin
          done_d  = 1'b1;
          count_d = fwr_pkg::CNT_W'(count_q - 1'b1);
          state_d = S_IDLE;
        end else begin
          rd_idx_d = fwr_pkg::CNT_W'(rd_idx_q + 1'b1);
        end
      end
    endcase

    if (done_d) begin
      rsp_d.fill_count = 5'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      rd_idx_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rsp_q <= rsp_d;
  end

  fwr_ram #(
    .Depth(fwr_pkg::DEPTH),
    .Width(32)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fwr_pkg::CNT_W'(fwr_pkg::DEPTH))
    else $error("fill level above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while a command is still running");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.cmd == fwr_pkg::CMD_ENQ || req_i.cmd == fwr_pkg::CMD_CLR))
      |=> (done_o && !busy))
    else $error("enqueue or clear did not finish in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE || state_q == S_SHIFT))
    else $error("RAM written outside enqueue or shift");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != fwr_pkg::ST_OK) |-> (rsp_o.out_value == '0))
    else $error("failed command returned a nonzero value");

endmodule
